// ===== design/blt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blt_pkg
// Shared types and constants for the bus load LED timer bank.
// ----------------------------------------------------------------------------
package blt_pkg;

  localparam int NumBuses  = 4;
  localparam int TimeBits  = 16;
  localparam int CountBits = 16;
  localparam int LedBits   = 4;

  localparam logic [7:0] WindowReset = 8'd10;
  localparam logic [3:0] ShiftReset  = 4'd4;

  localparam logic [1:0] CmdTick     = 2'd0;
  localparam logic [1:0] CmdPacket   = 2'd1;
  localparam logic [1:0] CmdSetRed   = 2'd2;
  localparam logic [1:0] CmdSetGreen = 2'd3;

  localparam logic RegWindow = 1'b0;
  localparam logic RegShift  = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  bus;
    logic [15:0] duration;
  } in_item_t;

  typedef struct packed {
    logic [3:0] red_leds;
    logic [3:0] green_leds;
  } out_item_t;

  typedef struct packed {
    logic [7:0] window_ticks;
    logic [3:0] load_shift;
  } cfg_t;

endpackage

// ===== design/blt_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blt_cfg
// Register file for window length and load shift, written over APB.
// ----------------------------------------------------------------------------
module blt_cfg import blt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [7:0] window_q;
  logic [3:0] shift_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
      shift_q  <= ShiftReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegWindow: window_q <= pwdata[7:0];
        RegShift:  shift_q  <= pwdata[3:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegWindow: prdata = {24'd0, window_q};
      RegShift:  prdata = {28'd0, shift_q};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg_o.window_ticks = window_q;
  assign cfg_o.load_shift   = shift_q;

endmodule

// ===== design/blt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blt_core
// Timer, packet counter and window state with the per-item update logic.
// ----------------------------------------------------------------------------
module blt_core import blt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  logic [TimeBits-1:0]  red_q   [NumBuses];
  logic [TimeBits-1:0]  red_d   [NumBuses];
  logic [TimeBits-1:0]  green_q [NumBuses];
  logic [TimeBits-1:0]  green_d [NumBuses];
  logic [CountBits-1:0] pkt_q   [NumBuses];
  logic [CountBits-1:0] pkt_d   [NumBuses];
  logic [7:0]           win_q;
  logic [7:0]           win_d;
  logic [8:0]           win_next;
  logic                 is_tick;
  logic                 close_win;
  logic                 bus_ok;
  logic [NumBuses-1:0]  red_lit;
  logic [NumBuses-1:0]  green_lit;

  assign is_tick   = step_i && (item_i.cmd == CmdTick);
  assign win_next  = {1'b0, win_q} + 9'd1;
  assign close_win = is_tick && (win_next >= {1'b0, cfg_i.window_ticks});
  assign bus_ok    = (32'(item_i.bus) < NumBuses);

  always_comb begin
    win_d = win_q;
    if (is_tick) begin
      win_d = close_win ? 8'd0 : win_next[7:0];
    end
    for (int b = 0; b < NumBuses; b++) begin
      red_lit[b]   = (red_q[b] != '0);
      green_lit[b] = (green_q[b] != '0);
      red_d[b]     = red_q[b];
      green_d[b]   = green_q[b];
      pkt_d[b]     = pkt_q[b];
      if (is_tick) begin
        if (red_lit[b]) begin
          red_d[b] = red_q[b] - TimeBits'(1);
        end
        if (green_lit[b]) begin
          green_d[b] = green_q[b] - TimeBits'(1);
        end
        if (close_win) begin
          if (pkt_q[b] != '0) begin
            green_d[b] = TimeBits'(pkt_q[b] >> cfg_i.load_shift);
          end
          pkt_d[b] = '0;
        end
      end else if (step_i && bus_ok && (32'(item_i.bus) == b)) begin
        case (item_i.cmd)
          CmdPacket: begin
            if (pkt_q[b] != '1) begin
              pkt_d[b] = pkt_q[b] + CountBits'(1);
            end
          end
          CmdSetRed:   red_d[b]   = TimeBits'(item_i.duration);
          CmdSetGreen: green_d[b] = TimeBits'(item_i.duration);
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      for (int b = 0; b < NumBuses; b++) begin
        red_q[b]   <= '0;
        green_q[b] <= '0;
        pkt_q[b]   <= '0;
      end
    end else begin
      win_q <= win_d;
      for (int b = 0; b < NumBuses; b++) begin
        red_q[b]   <= red_d[b];
        green_q[b] <= green_d[b];
        pkt_q[b]   <= pkt_d[b];
      end
    end
  end

  assign result_o.red_leds   = LedBits'(red_lit);
  assign result_o.green_leds = LedBits'(green_lit);

  a_close_clears_window: assert property (
    @(posedge clk_i) disable iff (!rst_ni) close_win |=> (win_q == 8'd0))
    else $error("window count not cleared at window close");

  a_non_tick_keeps_window: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !is_tick |=> $stable(win_q))
    else $error("window count moved without a tick");

  a_close_clears_counters: assert property (
    @(posedge clk_i) disable iff (!rst_ni) close_win |=> (pkt_q[0] == '0))
    else $error("packet counter not cleared at window close");

endmodule

// ===== design/bus_load_led_timer_bank_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_load_led_timer_bank_unit
// Per-bus red and green LED countdown timers with bus load measurement.
// ----------------------------------------------------------------------------
// Output: a tick item's LED masks pass from the input register to the result
//   register, which is loaded only while the output is free.
// Throughput: one item per cycle while no tick waits on a stalled output; all
//   state updates in one pass from the input register.
// Reset: clears all timers, packet counters and the window count; registers
//   return to window_ticks 10 and load_shift 4.
module bus_load_led_timer_bank_unit import blt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  logic      in_valid_d;
  out_item_t out_q;
  out_item_t result;
  logic      out_valid_q;
  logic      out_valid_d;
  logic      out_free;
  logic      step;
  logic      step_tick;
  logic      in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && ((in_q.cmd != CmdTick) || out_free);
  assign step_tick  = step && (in_q.cmd == CmdTick);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step_tick) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (step_tick) begin
      out_q <= result;
    end
  end

  blt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  blt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_tick_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) step_tick |=> out_valid_q)
    else $error("tick item produced no result");

  a_held_item_stable: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_q)))
    else $error("pending item lost while waiting");

  a_tick_never_overwrites: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    step_tick |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

// ===== tb/tb_bus_load_led_timer_bank_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bus_load_led_timer_bank_unit
// Drives command items into the LED timer bank and checks every LED mask
// against a cycle-free predictor of the red/green countdown timers, packet
// counters and measurement window. Covers zero-length windows, shortening a
// window mid-count and register readback, then random traffic under several
// register settings with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_bus_load_led_timer_bank_unit import blt_pkg::*; ();

  localparam int CycleLimit   = 1000000;
  localparam int SettleCycles = 8;
  localparam int PhaseItems   = 265;
  localparam int NumPhases    = 6;

  typedef struct packed {
    logic     drain;
    in_item_t item;
  } queued_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  bus_load_led_timer_bank_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  // Predicted block state
  logic [7:0]           win_len   = WindowReset;
  logic [3:0]           shift_amt = ShiftReset;
  logic [TimeBits-1:0]  red_t   [NumBuses] = '{default: '0};
  logic [TimeBits-1:0]  green_t [NumBuses] = '{default: '0};
  logic [CountBits-1:0] pkt_cnt [NumBuses] = '{default: '0};
  logic [7:0]           win_cnt = '0;

  queued_item_t cmd_q [$];
  out_item_t    led_q [$];

  int mismatches = 0;
  int cycles     = 0;
  int send_gap   = 0;
  int stall_left = 0;
  bit quiet_in   = 1'b0;
  bit quiet_out  = 1'b0;

  task automatic flag(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h at %0t ns", what, want, got, $time);
  endtask

  task automatic step_timers(input in_item_t it);
    out_item_t  leds;
    logic [8:0] nxt;
    if (it.cmd == CmdTick) begin
      leds = '0;
      for (int b = 0; b < NumBuses; b++) begin
        if (red_t[b] != '0) begin
          leds.red_leds[b] = 1'b1;
          red_t[b] = red_t[b] - 1'b1;
        end
        if (green_t[b] != '0) begin
          leds.green_leds[b] = 1'b1;
          green_t[b] = green_t[b] - 1'b1;
        end
      end
      nxt = {1'b0, win_cnt} + 9'd1;
      if (nxt >= {1'b0, win_len}) begin
        win_cnt = '0;
        for (int b = 0; b < NumBuses; b++) begin
          if (pkt_cnt[b] != '0)
            green_t[b] = pkt_cnt[b] >> shift_amt;
          pkt_cnt[b] = '0;
        end
      end else begin
        win_cnt = nxt[7:0];
      end
      led_q.push_back(leds);
    end else if (it.cmd == CmdPacket) begin
      if (pkt_cnt[it.bus] != '1)
        pkt_cnt[it.bus] = pkt_cnt[it.bus] + 1'b1;
    end else if (it.cmd == CmdSetRed) begin
      red_t[it.bus] = it.duration;
    end else begin
      green_t[it.bus] = it.duration;
    end
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t rand_cmd();
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 40)
      it.cmd = CmdTick;
    else if (r < 72)
      it.cmd = CmdPacket;
    else if (r < 86)
      it.cmd = CmdSetRed;
    else
      it.cmd = CmdSetGreen;
    it.bus = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 9);
    if (r < 6)
      it.duration = 16'($urandom_range(0, 30));
    else if (r == 6)
      it.duration = 16'hFFFF;
    else if (r == 7)
      it.duration = 16'h0000;
    else
      it.duration = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic queue_cmd(input logic [1:0] cmd, input logic [1:0] bus,
                           input logic [15:0] dur, input logic drain);
    queued_item_t q;
    q.drain         = drain;
    q.item.cmd      = cmd;
    q.item.bus      = bus;
    q.item.duration = dur;
    cmd_q.push_back(q);
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || led_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic sel, input logic [7:0] value);
    logic [2:0]  addr;
    logic [31:0] got;
    addr = {sel, 2'b00};
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == RegWindow)
      win_len = value;
    else
      shift_amt = value[3:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == RegWindow && got[7:0] != win_len)
      flag("window_ticks readback", int'(win_len), int'(got[7:0]));
    if (sel == RegShift && got[3:0] != shift_amt)
      flag("load_shift readback", int'(shift_amt), int'(got[3:0]));
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin : drive_items
    logic         hold;
    queued_item_t nxt_item;
    if (rst_ni) begin
      hold = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        step_timers(in_item_i);
        hold = 1'b0;
        send_gap = pick_gap(quiet_in);
        if ($urandom_range(0, 199) == 0)
          quiet_in = !quiet_in;
      end
      if (!hold) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && led_q.size() > 0)) begin
          nxt_item = cmd_q.pop_front();
          in_item_i <= nxt_item.item;
          hold = 1'b1;
        end
      end
      in_valid_i <= hold;
    end
  end

  always @(posedge clk_i) begin : check_leds
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (led_q.size() == 0) begin
          flag("unexpected LED item", 0, int'(out_item_o));
        end else begin
          want = led_q.pop_front();
          if (want.red_leds != out_item_o.red_leds)
            flag("red_leds", int'(want.red_leds), int'(out_item_o.red_leds));
          if (want.green_leds != out_item_o.green_leds)
            flag("green_leds", int'(want.green_leds), int'(out_item_o.green_leds));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap(quiet_out);
        if ($urandom_range(0, 199) == 0)
          quiet_out = !quiet_out;
      end
    end
  end

  initial begin : run
    logic [7:0] win_set   [NumPhases];
    logic [3:0] shift_set [NumPhases];
    in_item_t   it;
    logic [1:0] burst_bus;
    int         n;
    int         len;
    bit         held;

    win_set   = '{8'd255, 8'd1, 8'd3, 8'd10, 8'd0, 8'd37};
    shift_set = '{4'd15, 4'd0, 4'd1, 4'd4, 4'd9, 4'd2};
    win_set[5]   = 8'($urandom_range(1, 255));
    shift_set[4] = 4'($urandom_range(0, 15));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: extremes of durations, every command
    queue_cmd(CmdSetRed,   2'd0, 16'hFFFF, 1'b0);
    queue_cmd(CmdSetRed,   2'd1, 16'h0001, 1'b0);
    queue_cmd(CmdSetRed,   2'd2, 16'h0000, 1'b0);
    queue_cmd(CmdSetRed,   2'd3, 16'h0003, 1'b0);
    queue_cmd(CmdSetGreen, 2'd0, 16'h0002, 1'b0);
    queue_cmd(CmdSetGreen, 2'd1, 16'hAAAA, 1'b0);
    queue_cmd(CmdSetGreen, 2'd2, 16'h5555, 1'b0);
    queue_cmd(CmdPacket,   2'd3, 16'h0000, 1'b0);
    repeat (20) queue_cmd(CmdPacket, 2'd2, 16'h0000, 1'b0);
    repeat (12) queue_cmd(CmdTick, 2'd0, 16'h0000, 1'b0);
    settle();

    // zero-length window: the window closes and green timers with packets load on every tick
    program_reg(RegWindow, 8'd0);
    program_reg(RegShift, 8'd0);
    repeat (3) queue_cmd(CmdPacket, 2'd0, 16'h0000, 1'b0);
    queue_cmd(CmdTick, 2'd0, 16'h0000, 1'b0);
    queue_cmd(CmdPacket, 2'd1, 16'h0000, 1'b0);
    repeat (5) queue_cmd(CmdTick, 2'd0, 16'h0000, 1'b0);
    settle();

    // shorten the window while it is counting
    program_reg(RegWindow, 8'd255);
    program_reg(RegShift, 8'd15);
    repeat (30) begin
      queue_cmd(CmdPacket, 2'd1, 16'h0000, 1'b0);
      queue_cmd(CmdTick, 2'd0, 16'h0000, 1'b0);
    end
    settle();
    program_reg(RegWindow, 8'd5);
    queue_cmd(CmdPacket, 2'd2, 16'h0000, 1'b0);
    repeat (3) queue_cmd(CmdTick, 2'd0, 16'h0000, 1'b0);
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      program_reg(RegWindow, win_set[p]);
      program_reg(RegShift, {4'd0, shift_set[p]});
      n = 0;
      held = 1'b0;
      while (n < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          burst_bus = 2'($urandom_range(0, 3));
          len = $urandom_range(8, 60);
          repeat (len)
            queue_cmd(CmdPacket, burst_bus, 16'($urandom_range(0, 65535)), 1'b0);
          n += len;
        end else begin
          it = rand_cmd();
          queue_cmd(it.cmd, it.bus, it.duration, !held && n >= PhaseItems / 2);
          if (n >= PhaseItems / 2)
            held = 1'b1;
          n++;
        end
      end
      settle();
    end

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
